### src/shic_pkg.sv
package shic_pkg;

    localparam int NUM_SEATS_DEF = 2;

    localparam int ADC_W   = 12;
    localparam int TEMP_W  = 6;
    localparam int LEVEL_W = 2;
    localparam int INT_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // full-scale conversion constants
    localparam int ADC_SCALE = 45;
    localparam int ADC_FULL  = 4095;

    localparam logic [TEMP_W-1:0] TEMP_MIN = TEMP_W'(5);
    localparam logic [TEMP_W-1:0] TEMP_MAX = TEMP_W'(40);

    localparam logic [TEMP_W-1:0] LOW_SP_RST  = TEMP_W'(25);
    localparam logic [TEMP_W-1:0] MED_SP_RST  = TEMP_W'(30);
    localparam logic [TEMP_W-1:0] HIGH_SP_RST = TEMP_W'(35);

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_BUTTON = 1'b1
    } t_command;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_SP  = 2'd0,
        REG_MED_SP  = 2'd1,
        REG_HIGH_SP = 2'd2
    } t_cfg_reg;

    typedef enum logic [LEVEL_W-1:0] {
        LVL_OFF  = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_MED  = 2'd2,
        LVL_HIGH = 2'd3
    } t_level;

    typedef enum logic [INT_W-1:0] {
        INT_OFF  = 3'd0,
        INT_LOW  = 3'd1,
        INT_MED  = 3'd2,
        INT_HIGH = 3'd3,
        INT_ERR  = 3'd4
    } t_intensity;

endpackage

### src/shic_in_if.sv
interface shic_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic                        seat;
    logic [shic_pkg::ADC_W-1:0]  adc_sample;

    modport source (output valid, output command, output seat, output adc_sample,
                    input ready);
    modport sink   (input valid, input command, input seat, input adc_sample,
                    output ready);
endinterface

### src/shic_out_if.sv
interface shic_out_if;
    logic                          valid;
    logic                          ready;
    logic                          seat_out;
    logic [shic_pkg::TEMP_W-1:0]   temperature;
    logic                          temp_in_range;
    logic [shic_pkg::LEVEL_W-1:0]  desired_level;
    logic [shic_pkg::INT_W-1:0]    intensity;
    logic                          intensity_updated;

    modport source (output valid, output seat_out, output temperature,
                    output temp_in_range, output desired_level, output intensity,
                    output intensity_updated, input ready);
    modport sink   (input valid, input seat_out, input temperature,
                    input temp_in_range, input desired_level, input intensity,
                    input intensity_updated, output ready);
endinterface

### src/seat_heater_intensity_controller.sv
// channel   | dir | handshake        | payload
// i_req     | in  | valid / ready    | command, seat, adc_sample
// o_res     | out | valid / ready    | seat_out, temperature, temp_in_range,
//           |     |                  | desired_level, intensity, intensity_updated
// i_cfg_*   | in  | write enable     | register index, setpoint data
//
// one request per cycle while the result is not stalled; a request passes through the
// input register, then the result register, which holds the updated seat state
// the per-seat stores are written at the same edge as the result register, so a
// request for the same seat in the next cycle sees the update
// synchronous active-low reset clears the seat stores and restores setpoints
// a stalled result holds the pipe; the input register takes a request only while it is empty
module seat_heater_intensity_controller #(
    parameter int NUM_SEATS = shic_pkg::NUM_SEATS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    shic_in_if.sink                           i_req,
    shic_out_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [shic_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [shic_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int TW    = shic_pkg::TEMP_W;
    localparam int LW    = shic_pkg::LEVEL_W;
    localparam int IW    = shic_pkg::INT_W;
    localparam int AW    = shic_pkg::ADC_W;
    // seat field is one bit wide, so at most two seats are addressable
    localparam int DEPTH = (NUM_SEATS < 2) ? NUM_SEATS : 2;
    localparam int SCW   = $clog2(NUM_SEATS + 1) + 1;
    localparam int PW    = AW + $clog2(shic_pkg::ADC_SCALE + 1);
    localparam int QW    = PW - AW;
    localparam int RW    = AW + 1;

    // setpoints
    logic [TW-1:0] r_low_sp, r_med_sp, r_high_sp;

    // per-seat stores
    logic [TW-1:0] r_temp  [DEPTH];
    logic [LW-1:0] r_level [DEPTH];
    logic [IW-1:0] r_int   [DEPTH];

    // input register
    logic          r_in_valid;
    logic          r_in_cmd;
    logic          r_in_seat;
    logic [AW-1:0] r_in_adc;

    // result register
    logic          r_out_valid;
    logic          r_out_seat;
    logic [TW-1:0] r_out_temp;
    logic          r_out_in_range;
    logic [LW-1:0] r_out_level;
    logic [IW-1:0] r_out_int;
    logic          r_out_updated;

    logic          advance;
    logic          seat_ok;
    logic [TW-1:0] cur_temp;
    logic [LW-1:0] cur_level;
    logic [IW-1:0] cur_int;
    logic [PW-1:0] adc_prod;
    logic [QW-1:0] quo0;
    logic [RW-1:0] rem0;
    logic [TW-1:0] now_temp;
    logic          changed;
    logic [TW-1:0] n_temp;
    logic [LW-1:0] n_level;
    logic [IW-1:0] n_int;
    logic          do_rc;
    logic [TW-1:0] setpt;
    logic [TW:0]   t7, d7;
    logic          in_range;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign seat_ok     = SCW'(r_in_seat) < SCW'(NUM_SEATS);

    // read the addressed seat
    always_comb begin
        cur_temp  = '0;
        cur_level = '0;
        cur_int   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_in_seat == 1'(i)) begin
                cur_temp  = r_temp[i];
                cur_level = r_level[i];
                cur_int   = r_int[i];
            end
        end
    end

    // floor(adc*45/4095): divide by 4096, then one correction step
    always_comb begin
        adc_prod = PW'(r_in_adc) * PW'(shic_pkg::ADC_SCALE);
        quo0     = adc_prod[PW-1:AW];
        rem0     = RW'(adc_prod[AW-1:0]) + RW'(quo0);
        if (rem0 >= RW'(shic_pkg::ADC_FULL)) begin
            now_temp = TW'(quo0) + TW'(1);
        end else begin
            now_temp = TW'(quo0);
        end
        changed = ((TW+1)'(cur_temp) + (TW+1)'(3) < (TW+1)'(now_temp)) ||
                  ((TW+1)'(cur_temp) > (TW+1)'(now_temp) + (TW+1)'(3));
    end

    // update and recompute
    always_comb begin
        n_temp  = cur_temp;
        n_level = cur_level;
        do_rc   = 1'b0;
        if (r_in_cmd == shic_pkg::CMD_BUTTON) begin
            n_level = cur_level + LW'(1);
            do_rc   = 1'b1;
        end else begin
            n_temp = now_temp;
            do_rc  = changed;
        end

        case (n_level)
            shic_pkg::LVL_LOW:  setpt = r_low_sp;
            shic_pkg::LVL_MED:  setpt = r_med_sp;
            shic_pkg::LVL_HIGH: setpt = r_high_sp;
            default:            setpt = '0;
        endcase

        t7       = (TW+1)'(n_temp);
        d7       = (TW+1)'(setpt);
        in_range = (n_temp >= shic_pkg::TEMP_MIN) && (n_temp <= shic_pkg::TEMP_MAX);

        n_int = cur_int;
        if (do_rc) begin
            if (!in_range) begin
                n_int = shic_pkg::INT_ERR;
            end else if (cur_int != shic_pkg::INT_OFF) begin
                if (t7 + (TW+1)'(10) < d7) begin
                    n_int = shic_pkg::INT_HIGH;
                end else if (t7 + (TW+1)'(5) < d7) begin
                    n_int = shic_pkg::INT_MED;
                end else if (t7 + (TW+1)'(2) < d7) begin
                    n_int = shic_pkg::INT_LOW;
                end else if (t7 > d7) begin
                    n_int = shic_pkg::INT_OFF;
                end
            end else if (t7 + (TW+1)'(3) < d7) begin
                n_int = shic_pkg::INT_LOW;
            end
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_sp  <= shic_pkg::LOW_SP_RST;
            r_med_sp  <= shic_pkg::MED_SP_RST;
            r_high_sp <= shic_pkg::HIGH_SP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                shic_pkg::REG_LOW_SP:  r_low_sp  <= i_cfg_data;
                shic_pkg::REG_MED_SP:  r_med_sp  <= i_cfg_data;
                shic_pkg::REG_HIGH_SP: r_high_sp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // seat stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_temp[i]  <= '0;
                r_level[i] <= shic_pkg::LVL_OFF;
                r_int[i]   <= shic_pkg::INT_OFF;
            end
        end else if (advance && seat_ok) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (r_in_seat == 1'(i)) begin
                    r_temp[i]  <= n_temp;
                    r_level[i] <= n_level;
                    r_int[i]   <= n_int;
                end
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_cmd  <= i_req.command;
            r_in_seat <= i_req.seat;
            r_in_adc  <= i_req.adc_sample;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_seat <= r_in_seat;
            if (seat_ok) begin
                r_out_temp     <= n_temp;
                r_out_in_range <= in_range;
                r_out_level    <= n_level;
                r_out_int      <= n_int;
                r_out_updated  <= do_rc;
            end else begin
                r_out_temp     <= '0;
                r_out_in_range <= 1'b0;
                r_out_level    <= '0;
                r_out_int      <= '0;
                r_out_updated  <= 1'b0;
            end
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.seat_out          = r_out_seat;
    assign o_res.temperature       = r_out_temp;
    assign o_res.temp_in_range     = r_out_in_range;
    assign o_res.desired_level     = r_out_level;
    assign o_res.intensity         = r_out_int;
    assign o_res.intensity_updated = r_out_updated;

endmodule
